[sv/button_hold_progress_classifier_assert.svh]
// assertion macros for the button hold progress classifier
`ifndef BUTTON_HOLD_PROGRESS_CLASSIFIER_ASSERT_SVH
`define BUTTON_HOLD_PROGRESS_CLASSIFIER_ASSERT_SVH

// same-cycle implication
`define BHPC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BHPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[sv/bhpc_pkg.sv]
// shared types and constants for the button hold progress classifier
`timescale 1ns / 1ps
`default_nettype none

package bhpc_pkg;

    localparam int TIME_BITS      = 48;
    localparam int REG_W          = 24;
    localparam int DATA_W         = 32;
    localparam int PADDR_W        = 3;
    localparam int PROGRESS_STEPS = 10;
    localparam int FRACTION_BITS  = 10;
    localparam int FRAC_W         = FRACTION_BITS + 1;
    localparam int BKT_W          = 5;
    localparam int EV_W           = 3;
    localparam int STEP_QW        = $clog2(PROGRESS_STEPS);
    localparam int NUM_W          = REG_W + STEP_QW;
    localparam int STEP_CW        = $clog2(FRACTION_BITS);
    localparam int CNT_W          = $clog2(TIME_BITS);

    localparam logic [REG_W-1:0]  DEB_RESET   = REG_W'(70000);
    localparam logic [REG_W-1:0]  LP_RESET    = REG_W'(1000000);
    localparam logic [BKT_W-1:0]  BUCKET_NONE = '1;
    localparam logic [FRAC_W-1:0] FRAC_ONE    = {1'b1, {FRACTION_BITS{1'b0}}};

    typedef enum logic [EV_W-1:0] {
        EV_PROGRESS = 3'd0,
        EV_SHORT    = 3'd1,
        EV_LONG     = 3'd2,
        EV_CANCEL   = 3'd3,
        EV_COMPLETE = 3'd4
    } t_event;

    typedef enum logic [0:0] {
        REG_DEBOUNCE   = 1'b0,
        REG_LONG_PRESS = 1'b1
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SERIAL,
        S_DECIDE,
        S_DIV,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic                     done;
        logic [STEP_QW-1:0]       bucket;
        logic [FRACTION_BITS-1:0] frac;
    } t_div_res;

endpackage

`default_nettype wire

[sv/bhpc_div.sv]
// bit-serial restoring divider for hold fraction and progress bucket
`timescale 1ns / 1ps
`default_nettype none

module bhpc_div import bhpc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [REG_W-1:0] i_held,
    input  logic [REG_W-1:0] i_lp,
    output t_div_res         o_res
);

    logic                     r_busy;
    logic                     r_phase;
    logic [STEP_CW-1:0]       r_step;
    logic [REG_W-1:0]         r_rem;
    logic [STEP_QW-1:0]       r_num;
    logic [FRACTION_BITS-1:0] r_quo;
    logic [FRACTION_BITS-1:0] r_frac;
    logic [STEP_QW-1:0]       r_bkt;
    logic                     r_done;

    logic                     w_num_bit;
    logic [REG_W:0]           w_rem2;
    logic [REG_W:0]           w_sub;
    logic                     w_ge;
    logic [REG_W-1:0]         w_rem_n;
    logic [FRACTION_BITS-1:0] w_quo_n;
    logic [NUM_W-1:0]         w_n;

    assign w_num_bit = r_phase ? r_num[STEP_QW-1] : 1'b0;
    assign w_rem2    = {r_rem, w_num_bit};
    assign w_sub     = w_rem2 - {1'b0, i_lp};
    assign w_ge      = (w_rem2 >= {1'b0, i_lp});
    assign w_rem_n   = w_ge ? w_sub[REG_W-1:0] : w_rem2[REG_W-1:0];
    assign w_quo_n   = {r_quo[FRACTION_BITS-2:0], w_ge};
    assign w_n       = NUM_W'(i_held) * NUM_W'(PROGRESS_STEPS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= 1'b0;
            r_step  <= '0;
            r_done  <= 1'b0;
        end else begin
            if (i_start) begin
                r_busy  <= 1'b1;
                r_phase <= 1'b0;
                r_step  <= '0;
                r_rem   <= i_held;
                r_num   <= '0;
                r_quo   <= '0;
                r_done  <= 1'b0;
            end else if (r_busy) begin
                r_quo <= w_quo_n;
                if (!r_phase && r_step == STEP_CW'(FRACTION_BITS - 1)) begin
                    // fraction quotient done, switch to the bucket quotient
                    r_frac  <= w_quo_n;
                    r_phase <= 1'b1;
                    r_step  <= '0;
                    r_rem   <= w_n[NUM_W-1:STEP_QW];
                    r_num   <= w_n[STEP_QW-1:0];
                    r_done  <= 1'b0;
                end else begin
                    r_rem  <= w_rem_n;
                    r_num  <= r_num << 1;
                    r_step <= r_step + STEP_CW'(1);
                    if (r_phase && r_step == STEP_CW'(STEP_QW - 1)) begin
                        r_bkt  <= w_quo_n[STEP_QW-1:0];
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end else begin
                        r_done <= 1'b0;
                    end
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_res.done   = r_done;
    assign o_res.bucket = r_bkt;
    assign o_res.frac   = r_frac;

endmodule

`default_nettype wire

[sv/button_hold_progress_classifier.sv]
// top level: debounced button hold classifier with progress reporting
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one poll beat: raw level and
//   a 48-bit microsecond timestamp. Output channel (o_out_valid / i_out_ready)
//   gives zero to three result beats per poll, o_last_of_run on the final one.
//   An APB-style port sets the debounce time (0x0) and long press time (0x4).
// Timing:
//   A poll is accepted only while the block is idle. Both timestamp
//   differences and their compares run bit-serially, one bit a cycle, before
//   a decision state. A hold still short of the long press time then goes
//   through a one-bit-a-cycle divider: 10 fraction bits and 4 bucket bits.
//   Result beats leave one at a time, each once the output register is free.
//   The last result sits in an output register while the next poll is taken.
// Reset:
//   Synchronous, active low: registers return to 70000 us and 1000000 us,
//   button is released and no hold is tracked.
// Stall:
//   When the receiver holds i_out_ready low, the pending results wait and no
//   new poll is accepted until all but the last of them have left.
`timescale 1ns / 1ps
`default_nettype none

module button_hold_progress_classifier import bhpc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_pressed_raw,
    input  logic [TIME_BITS-1:0] i_time_now,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [EV_W-1:0]      o_event_kind,
    output logic [FRAC_W-1:0]    o_hold_fraction,
    output logic                 o_last_of_run,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]    pwdata,
    output logic [DATA_W-1:0]    prdata,
    output logic                 pready
);

    t_state                r_state;
    t_state                n_state;

    logic [REG_W-1:0]      r_debounce;
    logic [REG_W-1:0]      r_long_press;
    logic [REG_W-1:0]      w_lp_eff;
    t_reg_idx              w_reg_idx;

    logic                  r_raw_prev;
    logic                  r_changed;
    logic                  r_stable;
    logic                  r_long_done;
    logic [BKT_W-1:0]      r_bucket;
    logic [TIME_BITS-1:0]  r_chg;
    logic [TIME_BITS-1:0]  r_press;
    logic [TIME_BITS-1:0]  r_now_sh;
    logic [REG_W-1:0]      r_deb_sh;
    logic [REG_W-1:0]      r_lp_sh;
    logic [REG_W-1:0]      r_held;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_bw1;
    logic                  r_bw2;
    logic                  r_lt1;
    logic                  r_lt2;

    t_event                r_q0;
    t_event                r_q1;
    t_event                r_q2;
    logic [1:0]            r_q_n;
    logic [FRAC_W-1:0]     r_frac;

    logic                  r_out_valid;
    t_event                r_out_kind;
    logic [FRAC_W-1:0]     r_out_frac;
    logic                  r_out_last;

    logic                  w_accept;
    logic                  w_shift;
    logic                  w_edge;
    logic                  w_hold;
    logic                  w_held_ge;
    logic                  w_bkt_new;
    logic                  w_do_press;
    logic                  w_do_release;
    logic                  w_do_long;
    logic                  w_bucket_upd;
    logic                  w_div_start;
    logic                  w_emit;
    logic                  w_load_q;
    t_event                w_q0;
    t_event                w_q1;
    t_event                w_q2;
    logic [1:0]            w_q_n;
    logic [FRAC_W-1:0]     w_frac;
    t_div_res              w_div;

    logic                  w_now_b;
    logic                  w_chg_b;
    logic                  w_press_b;
    logic                  w_d1;
    logic                  w_d2;

    // configuration port
    assign pready    = 1'b1;
    assign w_reg_idx = t_reg_idx'(paddr[PADDR_W-1:2]);
    assign w_lp_eff  = (r_long_press == '0) ? REG_W'(1) : r_long_press;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce   <= DEB_RESET;
            r_long_press <= LP_RESET;
        end else if (psel && penable && pwrite && pready) begin
            case (w_reg_idx)
                REG_DEBOUNCE:   r_debounce   <= pwdata[REG_W-1:0];
                REG_LONG_PRESS: r_long_press <= pwdata[REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_DEBOUNCE:   prdata = DATA_W'(r_debounce);
            REG_LONG_PRESS: prdata = DATA_W'(r_long_press);
            default:        prdata = '0;
        endcase
    end

    // bit-serial subtract and compare, lsb first
    assign w_now_b   = r_now_sh[0];
    assign w_chg_b   = r_changed ? w_now_b : r_chg[0];
    assign w_press_b = r_press[0];
    assign w_d1      = w_now_b ^ w_chg_b ^ r_bw1;
    assign w_d2      = w_now_b ^ w_press_b ^ r_bw2;

    // decision terms
    assign w_edge    = (r_stable != r_raw_prev);
    assign w_hold    = r_stable && !r_long_done;
    assign w_held_ge = !r_lt2;
    assign w_bkt_new = (BKT_W'(w_div.bucket) != r_bucket);

    bhpc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_held  (r_held),
        .i_lp    (w_lp_eff),
        .o_res   (w_div)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_SERIAL;
            end
            S_SERIAL: begin
                if (r_cnt == CNT_W'(TIME_BITS - 1)) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (r_lt1) n_state = S_IDLE;
                else if (w_edge) n_state = S_EMIT;
                else if (w_hold) n_state = w_held_ge ? S_EMIT : S_DIV;
                else n_state = S_IDLE;
            end
            S_DIV: begin
                if (w_div.done) n_state = w_bkt_new ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (w_emit && r_q_n == 2'd1) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_in_ready   = 1'b0;
        w_shift      = 1'b0;
        w_do_press   = 1'b0;
        w_do_release = 1'b0;
        w_do_long    = 1'b0;
        w_bucket_upd = 1'b0;
        w_div_start  = 1'b0;
        w_emit       = 1'b0;
        w_load_q     = 1'b0;
        w_q0         = EV_PROGRESS;
        w_q1         = EV_CANCEL;
        w_q2         = EV_COMPLETE;
        w_q_n        = 2'd1;
        w_frac       = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
            end
            S_SERIAL: begin
                w_shift = 1'b1;
            end
            S_DECIDE: begin
                if (!r_lt1) begin
                    if (w_edge) begin
                        w_load_q = 1'b1;
                        if (r_raw_prev) begin
                            w_do_press = 1'b1;
                        end else begin
                            w_do_release = 1'b1;
                            if (r_long_done) begin
                                w_q0 = EV_CANCEL;
                            end else begin
                                w_q0  = EV_SHORT;
                                w_q_n = 2'd2;
                            end
                        end
                    end else if (w_hold) begin
                        if (w_held_ge) begin
                            w_do_long = 1'b1;
                            w_load_q  = 1'b1;
                            w_q1      = EV_LONG;
                            w_q_n     = 2'd3;
                            w_frac    = FRAC_ONE;
                        end else begin
                            w_div_start = 1'b1;
                        end
                    end
                end
            end
            S_DIV: begin
                if (w_div.done && w_bkt_new) begin
                    w_bucket_upd = 1'b1;
                    w_load_q     = 1'b1;
                    w_frac       = FRAC_W'(w_div.frac);
                end
            end
            S_EMIT: begin
                w_emit = !r_out_valid || i_out_ready;
            end
            default: ;
        endcase
    end

    assign w_accept = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // button state and serial datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_prev  <= 1'b0;
            r_changed   <= 1'b0;
            r_stable    <= 1'b0;
            r_long_done <= 1'b0;
            r_bucket    <= BUCKET_NONE;
            r_chg       <= '0;
            r_press     <= '0;
            r_cnt       <= '0;
            r_bw1       <= 1'b0;
            r_bw2       <= 1'b0;
            r_lt1       <= 1'b0;
            r_lt2       <= 1'b0;
        end else begin
            if (w_accept) begin
                r_raw_prev <= i_pressed_raw;
                r_changed  <= (i_pressed_raw != r_raw_prev);
                r_now_sh   <= i_time_now;
                r_deb_sh   <= r_debounce;
                r_lp_sh    <= w_lp_eff;
                r_cnt      <= '0;
                r_bw1      <= 1'b0;
                r_bw2      <= 1'b0;
                r_lt1      <= 1'b0;
                r_lt2      <= 1'b0;
            end
            if (w_shift) begin
                r_now_sh <= {w_now_b, r_now_sh[TIME_BITS-1:1]};
                r_chg    <= {w_chg_b, r_chg[TIME_BITS-1:1]};
                r_press  <= {w_press_b, r_press[TIME_BITS-1:1]};
                r_deb_sh <= {1'b0, r_deb_sh[REG_W-1:1]};
                r_lp_sh  <= {1'b0, r_lp_sh[REG_W-1:1]};
                r_bw1    <= (!w_now_b && w_chg_b) || (!(w_now_b ^ w_chg_b) && r_bw1);
                r_bw2    <= (!w_now_b && w_press_b) || (!(w_now_b ^ w_press_b) && r_bw2);
                if (w_d1 != r_deb_sh[0]) r_lt1 <= r_deb_sh[0];
                if (w_d2 != r_lp_sh[0])  r_lt2 <= r_lp_sh[0];
                if (r_cnt < CNT_W'(REG_W)) r_held <= {w_d2, r_held[REG_W-1:1]};
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (w_do_press) begin
                r_stable    <= 1'b1;
                r_press     <= r_now_sh;
                r_long_done <= 1'b0;
                r_bucket    <= '0;
            end
            if (w_do_release) begin
                r_stable <= 1'b0;
                r_bucket <= BUCKET_NONE;
            end
            if (w_do_long) begin
                r_long_done <= 1'b1;
                r_bucket    <= BUCKET_NONE;
            end
            if (w_bucket_upd) begin
                r_bucket <= BKT_W'(w_div.bucket);
            end
        end
    end

    // pending result queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_n <= '0;
        end else if (w_load_q) begin
            r_q0   <= w_q0;
            r_q1   <= w_q1;
            r_q2   <= w_q2;
            r_q_n  <= w_q_n;
            r_frac <= w_frac;
        end else if (w_emit) begin
            r_q0   <= r_q1;
            r_q1   <= r_q2;
            r_q_n  <= r_q_n - 2'd1;
            r_frac <= '0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
            r_out_kind  <= r_q0;
            r_out_frac  <= r_frac;
            r_out_last  <= (r_q_n == 2'd1);
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_event_kind    = r_out_kind;
    assign o_hold_fraction = r_out_frac;
    assign o_last_of_run   = r_out_last;

`include "button_hold_progress_classifier_assert.svh"

    `BHPC_ASSERT_NEXT(a_accept_starts_serial, w_accept, r_state == S_SERIAL,
        "accepted beat did not start the serial pass")
    `BHPC_ASSERT_NOW(a_long_done_clears_bucket, r_long_done, r_bucket == BUCKET_NONE,
        "bucket still tracked after long press")
    `BHPC_ASSERT_NOW(a_frac_only_progress,
        o_out_valid && o_event_kind != EV_PROGRESS, o_hold_fraction == '0,
        "fraction set on a non-progress beat")
    `BHPC_ASSERT_NOW(a_div_done_in_div, w_div.done, r_state == S_DIV,
        "divider finished outside the divide state")

endmodule

`default_nettype wire
